// ===== sv/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizes, header layout, item types,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package ffha_pkg;

    localparam int HEAP_UNITS   = 65536;
    localparam int HEADER_UNITS = 1;
    localparam int ADDR_W       = $clog2(HEAP_UNITS);
    localparam int SIZE_W       = 16;
    localparam int NEXT_W       = SIZE_W + 2;
    localparam int HDR_W        = SIZE_W + 2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_BAD_ADDRESS = 2'd2
    } t_status;

    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_RELEASE  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] request_size;
        logic [SIZE_W-1:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [SIZE_W-1:0] grant_address;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic              last;
        logic              free;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_CHK, S_A_SPLIT, S_R_CHK,
        S_C_START, S_C_LOAD, S_C_EVAL, S_C_N
    } t_state;

    typedef enum logic [1:0] { RD_ZERO, RD_NEXT_CUR, RD_NEXT_REG } t_rd_sel;
    typedef enum logic [1:0] { A_HOLD, A_ZERO, A_NEXT_CUR, A_NEXT_REG } t_a_op;
    typedef enum logic [1:0] { H_HOLD, H_LOAD_RD, H_LOAD_MERGED } t_h_op;
    typedef enum logic [2:0] {
        W_NONE, W_INIT, W_EXACT, W_SPLIT_TAIL, W_SPLIT_HEAD, W_FREE_MARK, W_MERGE
    } t_wr_op;

    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_a_op   a_op;
        t_h_op   h_op;
        t_wr_op  wr_op;
        logic    res_en;
        logic    res_grant;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_alloc;
        logic fit;
        logic exact;
        logic split_ok;
        logic last_cur;
        logic free_cur;
        logic addr_match;
        logic last_reg;
        logic both_free;
    } t_dp_stat;

endpackage

// ===== sv/ffha_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/ffha_datapath.sv =====
// Datapath of the heap allocator: header store, chain pointer, header register,
// compare logic and result register. Depends on ffha_pkg and ffha_ram.
module ffha_datapath (
    input  logic               i_clk,
    input  ffha_pkg::t_in_item i_item,
    input  ffha_pkg::t_dp_cmd  i_cmd,
    output ffha_pkg::t_dp_stat o_stat,
    output ffha_pkg::t_out_item o_result
);
    import ffha_pkg::*;

    localparam logic [NEXT_W-1:0] HeapN = NEXT_W'(HEAP_UNITS);
    localparam logic [NEXT_W-1:0] HdrN  = NEXT_W'(HEADER_UNITS);

    logic              r_cmd;
    logic [SIZE_W-1:0] r_req;
    logic [SIZE_W-1:0] r_rel;
    logic [ADDR_W-1:0] r_a;
    logic [ADDR_W-1:0] r_n;
    t_hdr              r_hdr;
    t_out_item         r_res;

    logic [HDR_W-1:0]  rd_data;
    t_hdr              cur;
    logic [NEXT_W-1:0] a_hdr;
    logic [NEXT_W-1:0] next_cur;
    logic [NEXT_W-1:0] next_reg;
    logic [NEXT_W-1:0] b_addr;
    logic [NEXT_W-1:0] merged;
    logic              we;
    logic [NEXT_W-1:0] waddr;
    t_hdr              wdata;
    logic [ADDR_W-1:0] raddr;

    assign cur      = t_hdr'(rd_data);
    assign a_hdr    = NEXT_W'(r_a) + HdrN;
    assign next_cur = a_hdr + NEXT_W'(cur.size);
    assign next_reg = a_hdr + NEXT_W'(r_hdr.size);
    assign b_addr   = a_hdr + NEXT_W'(r_req);
    assign merged   = NEXT_W'(r_hdr.size) + HdrN + NEXT_W'(cur.size);

    always_comb begin
        o_stat.is_alloc   = (r_cmd == CMD_ALLOCATE);
        o_stat.fit        = cur.free && (cur.size >= r_req);
        o_stat.exact      = (cur.size == r_req);
        o_stat.split_ok   = NEXT_W'(cur.size) > (NEXT_W'(r_req) + HdrN);
        o_stat.last_cur   = cur.last || (next_cur >= HeapN);
        o_stat.free_cur   = cur.free;
        o_stat.addr_match = (a_hdr == NEXT_W'(r_rel));
        o_stat.last_reg   = r_hdr.last || (next_reg >= HeapN);
        o_stat.both_free  = r_hdr.free && cur.free;
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_NEXT_CUR: raddr = next_cur[ADDR_W-1:0];
            RD_NEXT_REG: raddr = next_reg[ADDR_W-1:0];
            default:     raddr = '0;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = NEXT_W'(r_a);
        wdata = '0;
        unique case (i_cmd.wr_op)
            W_INIT: begin
                waddr = '0;
                wdata = '{last: 1'b1, free: 1'b1,
                          size: SIZE_W'(HEAP_UNITS - HEADER_UNITS)};
            end
            W_EXACT:      wdata = '{last: cur.last, free: 1'b0, size: cur.size};
            W_SPLIT_TAIL: begin
                waddr = b_addr;
                wdata = '{last: cur.last, free: 1'b1,
                          size: SIZE_W'(NEXT_W'(cur.size) - NEXT_W'(r_req) - HdrN)};
            end
            W_SPLIT_HEAD: wdata = '{last: 1'b0, free: 1'b0, size: r_req};
            W_FREE_MARK:  wdata = '{last: cur.last, free: 1'b1, size: cur.size};
            W_MERGE:      wdata = '{last: cur.last, free: 1'b1, size: merged[SIZE_W-1:0]};
            default:      we = 1'b0;
        endcase
        // Writes past the heap end are dropped.
        if (waddr >= HeapN) begin
            we = 1'b0;
        end
    end

    ffha_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_UNITS)) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr[ADDR_W-1:0]),
        .i_wdata(HDR_W'(wdata)),
        .i_re   (i_cmd.rd_en),
        .i_raddr(raddr),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd <= i_item.cmd;
            r_req <= i_item.request_size;
            r_rel <= i_item.release_address;
        end
        case (i_cmd.a_op)
            A_ZERO:     r_a <= '0;
            A_NEXT_CUR: r_a <= next_cur[ADDR_W-1:0];
            A_NEXT_REG: r_a <= r_n;
            default:    r_a <= r_a;
        endcase
        if (i_cmd.rd_sel == RD_NEXT_REG) begin
            r_n <= next_reg[ADDR_W-1:0];
        end
        case (i_cmd.h_op)
            H_LOAD_RD:     r_hdr <= cur;
            H_LOAD_MERGED: r_hdr <= '{last: cur.last, free: 1'b1, size: merged[SIZE_W-1:0]};
            default:       r_hdr <= r_hdr;
        endcase
        if (i_cmd.res_en) begin
            r_res.status        <= i_cmd.res_status;
            r_res.grant_address <= i_cmd.res_grant ? a_hdr[SIZE_W-1:0] : '0;
        end
    end

    assign o_result = r_res;
endmodule

// ===== sv/ffha_ctrl.sv =====
// Controller of the heap allocator: walks the header chain, sequences splits,
// releases and the merge pass, and raises the result strobe. Depends on ffha_pkg.
module ffha_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ffha_pkg::t_dp_stat i_stat,
    output ffha_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import ffha_pkg::*;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                // The command bit is only latched at acceptance, so the branch is
                // resolved in the cycle after; both walks start the same way.
                if (!i_stat.is_alloc) begin
                    n_state = S_R_CHK;
                end else if (i_stat.fit) begin
                    if (i_stat.exact) n_state = S_IDLE;
                    else if (i_stat.split_ok) n_state = S_A_SPLIT;
                    else n_state = S_IDLE;
                end else if (i_stat.last_cur) begin
                    n_state = S_IDLE;
                end
            end
            S_A_SPLIT: n_state = S_IDLE;
            S_R_CHK: begin
                if (i_stat.addr_match) begin
                    n_state = i_stat.free_cur ? S_IDLE : S_C_START;
                end else if (i_stat.last_cur) begin
                    n_state = S_IDLE;
                end
            end
            S_C_START: n_state = S_C_LOAD;
            S_C_LOAD:  n_state = S_C_EVAL;
            S_C_EVAL:  n_state = i_stat.last_reg ? S_IDLE : S_C_N;
            S_C_N:     n_state = S_C_EVAL;
            default:   n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = RD_ZERO;
        o_cmd.a_op       = A_HOLD;
        o_cmd.h_op       = H_HOLD;
        o_cmd.wr_op      = W_NONE;
        o_cmd.res_status = ST_OK;
        n_done           = 1'b0;
        unique case (r_state)
            S_INIT: o_cmd.wr_op = W_INIT;
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch_in = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.a_op     = A_ZERO;
                end
            end
            S_A_CHK: begin
                if (!i_stat.is_alloc) begin
                    // Release items pass through here once with the header at zero.
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_sel = RD_ZERO;
                end else if (i_stat.fit) begin
                    o_cmd.res_en = 1'b1;
                    if (i_stat.exact) begin
                        o_cmd.wr_op     = W_EXACT;
                        o_cmd.res_grant = 1'b1;
                        n_done          = 1'b1;
                    end else if (i_stat.split_ok) begin
                        o_cmd.wr_op     = W_SPLIT_TAIL;
                        o_cmd.res_grant = 1'b1;
                    end else begin
                        o_cmd.res_status = ST_NO_SPACE;
                        n_done           = 1'b1;
                    end
                end else if (i_stat.last_cur) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = ST_NO_SPACE;
                    n_done           = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT_CUR;
                    o_cmd.a_op   = A_NEXT_CUR;
                end
            end
            S_A_SPLIT: begin
                o_cmd.wr_op = W_SPLIT_HEAD;
                n_done      = 1'b1;
            end
            S_R_CHK: begin
                if (i_stat.addr_match) begin
                    if (i_stat.free_cur) begin
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = ST_BAD_ADDRESS;
                        n_done           = 1'b1;
                    end else begin
                        o_cmd.wr_op = W_FREE_MARK;
                    end
                end else if (i_stat.last_cur) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = ST_BAD_ADDRESS;
                    n_done           = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT_CUR;
                    o_cmd.a_op   = A_NEXT_CUR;
                end
            end
            S_C_START: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.a_op  = A_ZERO;
            end
            S_C_LOAD: o_cmd.h_op = H_LOAD_RD;
            S_C_EVAL: begin
                if (i_stat.last_reg) begin
                    o_cmd.res_en = 1'b1;
                    n_done       = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT_REG;
                end
            end
            S_C_N: begin
                if (i_stat.both_free) begin
                    // Stay on the same header: the merged block may absorb more.
                    o_cmd.wr_op = W_MERGE;
                    o_cmd.h_op  = H_LOAD_MERGED;
                end else begin
                    o_cmd.a_op = A_NEXT_REG;
                    o_cmd.h_op = H_LOAD_RD;
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
endmodule

// ===== sv/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath (which holds ffha_ram).
//
//   channel   handshake              payload
//   command   start / busy           i_item  (cmd, request_size, release_address)
//   result    o_done, one cycle      o_result (grant_address, status)
//
// An allocate strobes its result from state S_A_CHK when the first header decides it,
// walks one further header per S_A_CHK pass otherwise, and passes S_A_SPLIT on a split.
// A release passes S_A_CHK once before the same walk in S_R_CHK; a valid one then runs
// the setup states S_C_START and S_C_LOAD and one S_C_EVAL, S_C_N pair per merge or step
// along the chain, plus a last S_C_EVAL. The header memory reads one header per cycle, registered.
// After reset the block is busy while it writes the first header.
// The result is held in a register for its strobe cycle; the next item may start then.
module first_fit_heap_allocator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ffha_pkg::t_in_item  i_item,
    output logic                o_done,
    output ffha_pkg::t_out_item o_result
);
    import ffha_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ffha_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (dp_stat),
        .o_cmd  (dp_cmd),
        .o_busy (busy),
        .o_done (o_done)
    );

    ffha_datapath u_dp (
        .i_clk   (i_clk),
        .i_item  (i_item),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_result(o_result)
    );
endmodule

// ===== sim/ffha_checker.sv =====
// Checker for the first-fit heap allocator: keeps its own copy of the header chain,
// predicts the result of every accepted command and compares it with o_result.
// Depends on ffha_pkg.
module ffha_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  ffha_pkg::t_in_item  i_item,
    input  logic                o_done,
    input  ffha_pkg::t_out_item o_result,
    output int                  o_errors,
    output int                  o_pending
);
    import ffha_pkg::*;

    t_hdr      heap_hdr [HEAP_UNITS];
    t_out_item expected_results [$];

    function automatic int unsigned next_hdr(int unsigned a);
        return a + HEADER_UNITS + heap_hdr[a].size;
    endfunction

    function automatic bit chain_end(int unsigned a);
        return heap_hdr[a].last || next_hdr(a) >= HEAP_UNITS;
    endfunction

    // Merges each run of adjacent free blocks, however long, into its first block.
    function automatic void merge_free_runs();
        int unsigned a;
        int unsigned n;
        a = 0;
        while (!chain_end(a)) begin
            n = next_hdr(a);
            if (heap_hdr[a].free && heap_hdr[n].free) begin
                heap_hdr[a].size = SIZE_W'(heap_hdr[a].size + HEADER_UNITS
                                           + heap_hdr[n].size);
                heap_hdr[a].last = heap_hdr[n].last;
            end else begin
                a = n;
            end
        end
    endfunction

    function automatic t_out_item predict_allocate(int unsigned req);
        t_out_item   r;
        int unsigned a;
        int unsigned b;
        int unsigned sz;
        a = 0;
        r.grant_address = '0;
        r.status = ST_NO_SPACE;
        forever begin
            if (heap_hdr[a].free && heap_hdr[a].size >= req) break;
            if (chain_end(a)) break;
            a = next_hdr(a);
        end
        sz = heap_hdr[a].size;
        if (!heap_hdr[a].free) return r;
        if (sz == req) begin
            heap_hdr[a].free = 1'b0;
        end else if (sz > req + HEADER_UNITS) begin
            b = a + HEADER_UNITS + req;
            heap_hdr[b].size = SIZE_W'(sz - req - HEADER_UNITS);
            heap_hdr[b].free = 1'b1;
            heap_hdr[b].last = heap_hdr[a].last;
            heap_hdr[a] = '{last: 1'b0, free: 1'b0, size: req[SIZE_W-1:0]};
        end else begin
            return r;
        end
        r.grant_address = SIZE_W'(a + HEADER_UNITS);
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_out_item predict_release(int unsigned addr);
        t_out_item   r;
        int unsigned a;
        a = 0;
        r.grant_address = '0;
        r.status = ST_BAD_ADDRESS;
        forever begin
            if (a + HEADER_UNITS == addr) begin
                if (heap_hdr[a].free) return r;
                heap_hdr[a].free = 1'b1;
                merge_free_runs();
                r.status = ST_OK;
                return r;
            end
            if (chain_end(a)) return r;
            a = next_hdr(a);
        end
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            heap_hdr[0] = '{last: 1'b1, free: 1'b1,
                            size: SIZE_W'(HEAP_UNITS - HEADER_UNITS)};
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("ERROR: unexpected result grant=%0d status=%0d",
                                 o_result.grant_address, o_result.status);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r != o_result) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("ERROR: expected grant=%0d status=%0d, got grant=%0d status=%0d",
                                     exp_r.grant_address, exp_r.status,
                                     o_result.grant_address, o_result.status);
                    end
                end
            end
            if (start && !busy) begin
                if (i_item.cmd == CMD_ALLOCATE)
                    expected_results.push_back(predict_allocate(i_item.request_size));
                else
                    expected_results.push_back(predict_release(i_item.release_address));
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
// Testbench top for first_fit_heap_allocator_unit: directed and random allocate and
// release commands in bursts, checked by ffha_checker. Depends on ffha_pkg, the RTL
// and sim/ffha_checker.sv.
module tb;
    import ffha_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_done;
    t_out_item o_result;
    int        errors;
    int        pending;

    logic [SIZE_W-1:0] live_blocks [$];
    logic              issued_cmds [$];
    int                idle_cycles = 0;
    int                n_alloc = 0;
    int                n_release = 0;
    int                n_ok = 0;
    int                n_no_space = 0;
    int                n_bad = 0;
    int                burst_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    first_fit_heap_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    ffha_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .o_errors (errors),
        .o_pending(pending)
    );

    // Granted addresses are collected so that releases mostly hit live blocks.
    always @(posedge i_clk) begin
        logic was_alloc;
        if (i_rst_n) begin
            if (start && !busy) issued_cmds.push_back(i_item.cmd);
            if (o_done && issued_cmds.size() > 0) begin
                was_alloc = issued_cmds.pop_front();
                case (o_result.status)
                    ST_OK: n_ok++;
                    ST_NO_SPACE: n_no_space++;
                    default: n_bad++;
                endcase
                if (was_alloc == CMD_ALLOCATE && o_result.status == ST_OK)
                    live_blocks.push_back(o_result.grant_address);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send(logic cmd, logic [SIZE_W-1:0] sz, logic [SIZE_W-1:0] addr);
        int gap;
        if (cmd == CMD_ALLOCATE) n_alloc++;
        else n_release++;
        start <= 1'b1;
        i_item <= '{cmd: cmd, request_size: sz, release_address: addr};
        do @(posedge i_clk); while (busy);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic release_live();
        int k;
        logic [SIZE_W-1:0] a;
        if (live_blocks.size() == 0) begin
            send(CMD_RELEASE, SIZE_W'($urandom()), SIZE_W'($urandom()));
        end else begin
            k = $urandom_range(0, live_blocks.size() - 1);
            a = live_blocks[k];
            live_blocks.delete(k);
            send(CMD_RELEASE, SIZE_W'($urandom()), a);
        end
    endtask

    initial begin
        int r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Exact fit of the whole heap, then double release.
        send(CMD_ALLOCATE, 16'hFFFF, 16'h0000);
        send(CMD_ALLOCATE, 16'd0, 16'h0000);
        send(CMD_RELEASE, 16'h0000, 16'd1);
        send(CMD_RELEASE, 16'hFFFF, 16'd1);
        // Near fit, then a split leaving a one-unit tail taken exactly.
        send(CMD_ALLOCATE, 16'hFFFE, 16'hFFFF);
        send(CMD_ALLOCATE, 16'hFFFD, 16'h0000);
        send(CMD_ALLOCATE, 16'd1, 16'h0000);
        // Every block used: the walk ends at a used last block.
        send(CMD_ALLOCATE, 16'd0, 16'h0000);
        send(CMD_RELEASE, 16'h0000, 16'hFFFF);
        send(CMD_RELEASE, 16'h0000, 16'h0000);
        send(CMD_RELEASE, 16'h0000, 16'd2);
        send(CMD_RELEASE, 16'h0000, 16'd1);
        // Small blocks released in an order that leaves a run of three to merge.
        send(CMD_ALLOCATE, 16'd0, 16'h0000);
        send(CMD_ALLOCATE, 16'd3, 16'h0000);
        send(CMD_ALLOCATE, 16'd5, 16'h0000);
        send(CMD_ALLOCATE, 16'd2, 16'h0000);
        send(CMD_RELEASE, 16'h0000, 16'd2);
        send(CMD_RELEASE, 16'h0000, 16'd6);
        send(CMD_RELEASE, 16'h0000, 16'd1);
        send(CMD_ALLOCATE, 16'd5, 16'h0000);
        send(CMD_RELEASE, 16'h0000, 16'd12);
        send(CMD_RELEASE, 16'h0000, 16'd1);
        start <= 1'b0;
        while (pending > 0) @(posedge i_clk);
        live_blocks.delete();

        repeat (1300) begin
            r = $urandom_range(0, 99);
            if (live_blocks.size() > 48 && r < 60) r = 60;
            if (r < 45)
                send(CMD_ALLOCATE, SIZE_W'($urandom_range(0, 64)), SIZE_W'($urandom()));
            else if (r < 50)
                send(CMD_ALLOCATE,
                     SIZE_W'(($urandom_range(0, 1) == 1) ? $urandom()
                             : 32'hFFFF - $urandom_range(0, 3)),
                     SIZE_W'($urandom()));
            else if (r < 90)
                release_live();
            else if (r < 95 && live_blocks.size() > 0)
                send(CMD_RELEASE, SIZE_W'($urandom()),
                     SIZE_W'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                             + $urandom_range(1, 2)));
            else
                send(CMD_RELEASE, SIZE_W'($urandom()), SIZE_W'($urandom()));
        end
        start <= 1'b0;

        while (pending > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("%0d allocates and %0d releases: %0d ok, %0d no_space, %0d bad_address",
                 n_alloc, n_release, n_ok, n_no_space, n_bad);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
